@@ rtl/core/sms_text_gsm7_ucs2_packer_unit_assert.svh @@
// Assertion macros shared by the SMS packer RTL.
`ifndef SMS_TEXT_GSM7_UCS2_PACKER_UNIT_ASSERT_SVH
`define SMS_TEXT_GSM7_UCS2_PACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SMSPK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);
`define SMSPK_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);
`else
`define SMSPK_ASSERT(label, clk, rst, prop, msg)
`define SMSPK_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ rtl/core/smspk_pkg.sv @@
// Types, constants and the GSM 03.38 mapping function of the SMS packer.
`default_nettype none
package smspk_pkg;

   localparam int MaxResults     = 4;
   localparam int ResIdxWidth    = $clog2(MaxResults);
   localparam int QDepth         = 2;
   localparam int QPtrWidth      = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCountWidth    = $clog2(QDepth + 1);
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 3;

   localparam logic [CsrIndexWidth-1:0] CsrEncodingMode = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrLeadPadBits  = 2'd1;

   localparam logic [15:0] NoCode     = 16'hFFFF;
   localparam logic [6:0]  EscSeptet  = 7'h1B;
   localparam logic [20:0] MaxCp      = 21'h10FFFF;
   localparam logic [20:0] BmpMax     = 21'h00FFFF;
   localparam logic [20:0] SuppBase   = 21'h010000;
   localparam logic [5:0]  HiSurrTop  = 6'b110110;
   localparam logic [5:0]  LoSurrTop  = 6'b110111;

   typedef enum logic [1:0] {
      StatusData  = 2'd0,
      StatusNoMap = 2'd1,
      StatusEnd   = 2'd2
   } status_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       end_of_run;
   } rsp_type;

   // All results caused by one item, oldest in slot zero.
   typedef struct packed {
      rsp_type [MaxResults-1:0] res;
      logic [ResIdxWidth-1:0]   last;
   } bundle_type;

   // Returns the septet, the escape pair (0x1Bxx) or NoCode.
   function automatic logic [15:0] gsm_lookup(input logic [20:0] cp);
      logic [15:0] code;
      unique case (cp)
         21'h40:   code = 16'h00;
         21'h24:   code = 16'h02;
         21'h0A:   code = 16'h0A;
         21'h0D:   code = 16'h0D;
         21'h5F:   code = 16'h11;
         21'hA3:   code = 16'h01;
         21'hA5:   code = 16'h03;
         21'hE8:   code = 16'h04;
         21'hE9:   code = 16'h05;
         21'hF9:   code = 16'h06;
         21'hEC:   code = 16'h07;
         21'hF2:   code = 16'h08;
         21'hC7:   code = 16'h09;
         21'hD8:   code = 16'h0B;
         21'hF8:   code = 16'h0C;
         21'hC5:   code = 16'h0E;
         21'hE5:   code = 16'h0F;
         21'h394:  code = 16'h10;
         21'h3A6:  code = 16'h12;
         21'h393:  code = 16'h13;
         21'h39B:  code = 16'h14;
         21'h3A9:  code = 16'h15;
         21'h3A0:  code = 16'h16;
         21'h3A8:  code = 16'h17;
         21'h3A3:  code = 16'h18;
         21'h398:  code = 16'h19;
         21'h39E:  code = 16'h1A;
         21'hC6:   code = 16'h1C;
         21'hE6:   code = 16'h1D;
         21'hDF:   code = 16'h1E;
         21'hC9:   code = 16'h1F;
         21'hA4:   code = 16'h24;
         21'hA1:   code = 16'h40;
         21'hC4:   code = 16'h5B;
         21'hD6:   code = 16'h5C;
         21'hD1:   code = 16'h5D;
         21'hDC:   code = 16'h5E;
         21'hA7:   code = 16'h5F;
         21'hBF:   code = 16'h60;
         21'hE4:   code = 16'h7B;
         21'hF6:   code = 16'h7C;
         21'hF1:   code = 16'h7D;
         21'hFC:   code = 16'h7E;
         21'hE0:   code = 16'h7F;
         21'h20AC: code = 16'h1B65;
         21'h5E:   code = 16'h1B14;
         21'h7B:   code = 16'h1B28;
         21'h7D:   code = 16'h1B29;
         21'h5C:   code = 16'h1B2F;
         21'h5B:   code = 16'h1B3C;
         21'h7E:   code = 16'h1B3D;
         21'h5D:   code = 16'h1B3E;
         21'h7C:   code = 16'h1B40;
         21'h60:   code = NoCode;
         default: begin
            // Remaining printable ASCII maps onto itself.
            if (cp >= 21'h20 && cp <= 21'h7E) code = cp[15:0];
            else code = NoCode;
         end
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/smspk_front.sv @@
// Front end: maps each character, packs septets and builds its result bundle.
`default_nettype none
`include "sms_text_gsm7_ucs2_packer_unit_assert.svh"
module smspk_front import smspk_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       encoding_mode,
   input  wire logic [2:0] lead_pad_bits,
   input  wire logic       accept,
   input  wire req_type    req,
   output logic            push,
   output bundle_type      bundle
);

   logic [6:0] carry_bits_ff, carry_bits_in;
   logic [2:0] carry_count_ff, carry_count_in;
   logic       at_start_ff, at_start_in;

   logic [15:0] code;
   logic        mapped, two_sep;
   logic [13:0] sep_pair;
   logic [2:0]  base_cnt;
   logic [6:0]  base_bits;
   logic [20:0] stream;
   logic [4:0]  total;
   logic [1:0]  nbytes;
   logic [6:0]  new_bits, bits_after;
   logic [2:0]  cnt_after;
   logic [19:0] supp;
   logic [15:0] hi_unit, lo_unit;
   logic [2:0]  n;
   rsp_type [MaxResults-1:0] res;

   always_comb begin
      code      = gsm_lookup(req.code_point);
      mapped    = (code != NoCode);
      two_sep   = (code[15:8] != 8'd0);
      sep_pair  = two_sep ? {code[6:0], EscSeptet} : {7'd0, code[6:0]};
      base_cnt  = at_start_ff ? lead_pad_bits : carry_count_ff;
      base_bits = at_start_ff ? 7'd0 : carry_bits_ff;
      stream    = ({7'd0, sep_pair} << base_cnt) | {14'd0, base_bits};
      total     = {2'd0, base_cnt} + (two_sep ? 5'd14 : 5'd7);
      nbytes    = total[4:3];
      case (nbytes)
         2'd0:    new_bits = stream[6:0];
         2'd1:    new_bits = stream[14:8];
         default: new_bits = {2'd0, stream[20:16]};
      endcase
      bits_after = mapped ? new_bits : carry_bits_ff;
      cnt_after  = mapped ? total[2:0] : carry_count_ff;

      supp    = 20'(req.code_point - SuppBase);
      hi_unit = {HiSurrTop, supp[19:10]};
      lo_unit = {LoSurrTop, supp[9:0]};

      res = '0;
      n   = 3'd0;
      if (encoding_mode) begin
         if (req.code_point > MaxCp) begin
            res[0].status = StatusNoMap;
            n = 3'd1;
         end else if (req.code_point > BmpMax) begin
            res[0].out_byte = hi_unit[15:8];
            res[1].out_byte = hi_unit[7:0];
            res[2].out_byte = lo_unit[15:8];
            res[3].out_byte = lo_unit[7:0];
            n = 3'd4;
         end else begin
            res[0].out_byte = req.code_point[15:8];
            res[1].out_byte = req.code_point[7:0];
            n = 3'd2;
         end
      end else begin
         if (!mapped) begin
            res[0].status = StatusNoMap;
            n = 3'd1;
         end else begin
            if (nbytes != 2'd0) begin
               res[0].out_byte = stream[7:0];
               n = 3'd1;
            end
            if (nbytes == 2'd2) begin
               res[1].out_byte = stream[15:8];
               n = 3'd2;
            end
         end
         // Leftover bits leave zero filled at the top when the message ends.
         if (req.is_final && cnt_after != 3'd0) begin
            res[n[ResIdxWidth-1:0]].out_byte = {1'b0, bits_after};
            n = n + 3'd1;
         end
      end
      if (req.is_final) begin
         if (n == 3'd0) begin
            res[0].status = StatusEnd;
            n = 3'd1;
         end
         res[ResIdxWidth'(n - 3'd1)].end_of_run = 1'b1;
      end

      push        = accept && (n != 3'd0);
      bundle.res  = res;
      bundle.last = ResIdxWidth'(n - 3'd1);

      carry_bits_in  = carry_bits_ff;
      carry_count_in = carry_count_ff;
      at_start_in    = at_start_ff;
      if (accept) begin
         if (req.is_final) begin
            carry_bits_in  = 7'd0;
            carry_count_in = 3'd0;
            at_start_in    = 1'b1;
         end else if (!encoding_mode && mapped) begin
            carry_bits_in  = new_bits;
            carry_count_in = total[2:0];
            at_start_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_bits_ff  <= 7'd0;
         carry_count_ff <= 3'd0;
         at_start_ff    <= 1'b1;
      end else begin
         carry_bits_ff  <= carry_bits_in;
         carry_count_ff <= carry_count_in;
         at_start_ff    <= at_start_in;
      end
   end

   `SMSPK_ASSERT(a_start_no_carry, clock, reset, at_start_ff |-> (carry_count_ff == 3'd0), "carry bits pending at message start")
   `SMSPK_ASSERT(a_final_restarts, clock, reset, (accept && req.is_final) |=> at_start_ff, "message start not restored after final item")
   `SMSPK_ASSERT(a_final_pushes, clock, reset, (accept && req.is_final) |-> push, "final item produced no result")

endmodule
`default_nettype wire

@@ rtl/core/smspk_queue.sv @@
// Short bundle queue between the front end and the result sequencer.
`default_nettype none
`include "sms_text_gsm7_ucs2_packer_unit_assert.svh"
module smspk_queue import smspk_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   output logic            full,
   input  wire logic       pop,
   output logic            valid,
   output bundle_type      head
);

   bundle_type                 entry_ff [QDepth];
   logic [QPtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCountWidth-1:0]     count_ff, count_in;

   always_comb begin
      full  = (count_ff == QCountWidth'(QDepth));
      valid = (count_ff != '0);
      head  = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrWidth'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrWidth'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SMSPK_NEVER(a_q_overflow, clock, reset, push && full, "bundle pushed into a full queue")
   `SMSPK_NEVER(a_q_underflow, clock, reset, pop && !valid, "bundle popped from an empty queue")
   `SMSPK_NEVER(a_q_bound, clock, reset, count_ff > QCountWidth'(QDepth), "queue count out of range")

endmodule
`default_nettype wire

@@ rtl/core/smspk_back.sv @@
// Back end: hands out the results of each bundle one per cycle while rsp_pop is high.
`default_nettype none
`include "sms_text_gsm7_ucs2_packer_unit_assert.svh"
module smspk_back import smspk_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire bundle_type q_head,
   output logic            q_pop,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output rsp_type         rsp_data
);

   logic                   busy_ff, busy_in;
   logic [ResIdxWidth-1:0] idx_ff, idx_in;
   bundle_type             cur_ff, cur_in;
   logic                   take, at_last;

   always_comb begin
      rsp_empty = !busy_ff;
      rsp_data  = cur_ff.res[idx_ff];
      take      = busy_ff && rsp_pop;
      at_last   = (idx_ff == cur_ff.last);
      // The next bundle loads in the cycle the last result of this one leaves.
      q_pop     = q_valid && (!busy_ff || (take && at_last));

      busy_in = busy_ff;
      idx_in  = idx_ff;
      cur_in  = cur_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
         cur_in  = q_head;
      end else if (take) begin
         if (at_last) busy_in = 1'b0;
         else idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   `SMSPK_NEVER(a_idx_range, clock, reset, busy_ff && (idx_ff > cur_ff.last), "result index beyond bundle")
   `SMSPK_ASSERT(a_eor_last, clock, reset, (busy_ff && rsp_data.end_of_run) |-> at_last, "end of run before the last result")
   `SMSPK_ASSERT(a_rsp_hold, clock, reset, (busy_ff && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "waiting item changed before it was taken")

endmodule
`default_nettype wire

@@ rtl/core/sms_text_gsm7_ucs2_packer_unit.sv @@
// Top level of the SMS user-data packer (GSM 7-bit septets or UCS-2 octets).
//
//   channel   direction  handshake              payload
//   req_      in         req_push / req_full    req_type: code_point, is_final
//   rsp_      out        rsp_empty / rsp_pop    rsp_type: out_byte, status, end_of_run
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A character is taken whenever the bundle queue has room and gives up to
// four octets, which pass through the bundle queue and the back-end register
// and then leave one per cycle while rsp_pop is high; the result port sets
// the rate. Reset is synchronous and clears the packing state, the queue and
// the configuration registers. A stalled result port fills the two-entry
// queue and then raises req_full.
`default_nettype none
module sms_text_gsm7_ucs2_packer_unit import smspk_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire req_type                  req_data,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   logic       encoding_mode_ff, encoding_mode_in;
   logic [2:0] lead_pad_bits_ff, lead_pad_bits_in;
   logic       accept, push, q_full, q_pop, q_valid;
   bundle_type bundle, q_head;

   always_comb begin
      csr_ready        = 1'b1;
      encoding_mode_in = encoding_mode_ff;
      lead_pad_bits_in = lead_pad_bits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrEncodingMode: encoding_mode_in = csr_wdata[0];
            CsrLeadPadBits:  lead_pad_bits_in = csr_wdata[2:0];
            default: ;
         endcase
      end
      req_full = q_full;
      accept   = req_push && !q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_mode_ff <= 1'b0;
         lead_pad_bits_ff <= 3'd0;
      end else begin
         encoding_mode_ff <= encoding_mode_in;
         lead_pad_bits_ff <= lead_pad_bits_in;
      end
   end

   smspk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .encoding_mode (encoding_mode_ff),
      .lead_pad_bits (lead_pad_bits_ff),
      .accept        (accept),
      .req           (req_data),
      .push          (push),
      .bundle        (bundle)
   );

   smspk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   smspk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the SMS GSM 7-bit / UCS-2 user-data packer.
`default_nettype none
module tb_top import smspk_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RunLimit     = 500000;
   localparam int unsigned SettleCycles = 20;
   localparam int unsigned PhaseChars   = 24;
   localparam int unsigned RandomPhases = 9;

   localparam logic [20:0] Backtick = 21'h60;
   localparam logic [20:0] AsciiLow = 21'h20;
   localparam logic [20:0] AsciiTop = 21'h7E;
   localparam logic [15:0] HiSurrBase = 16'hD800;
   localparam logic [15:0] LoSurrBase = 16'hDC00;

   // Each entry is {code point, GSM code}; codes above 0xFF are escape pairs.
   localparam logic [31:0] GsmPairs [0:52] = '{
      32'h0040_0000, 32'h0024_0002, 32'h000A_000A, 32'h000D_000D, 32'h005F_0011,
      32'h00A3_0001, 32'h00A5_0003, 32'h00E8_0004, 32'h00E9_0005, 32'h00F9_0006,
      32'h00EC_0007, 32'h00F2_0008, 32'h00C7_0009, 32'h00D8_000B, 32'h00F8_000C,
      32'h00C5_000E, 32'h00E5_000F, 32'h0394_0010, 32'h03A6_0012, 32'h0393_0013,
      32'h039B_0014, 32'h03A9_0015, 32'h03A0_0016, 32'h03A8_0017, 32'h03A3_0018,
      32'h0398_0019, 32'h039E_001A, 32'h00C6_001C, 32'h00E6_001D, 32'h00DF_001E,
      32'h00C9_001F, 32'h00A4_0024, 32'h00A1_0040, 32'h00C4_005B, 32'h00D6_005C,
      32'h00D1_005D, 32'h00DC_005E, 32'h00A7_005F, 32'h00BF_0060, 32'h00E4_007B,
      32'h00F6_007C, 32'h00F1_007D, 32'h00FC_007E, 32'h00E0_007F,
      32'h20AC_1B65, 32'h005E_1B14, 32'h007B_1B28, 32'h007D_1B29, 32'h005C_1B2F,
      32'h005B_1B3C, 32'h007E_1B3D, 32'h005D_1B3E, 32'h007C_1B40
   };
   localparam int unsigned FirstEscPair = 44;

   localparam logic       ModePlan [0:RandomPhases-1] = '{0, 0, 1, 0, 0, 1, 0, 0, 1};
   localparam logic [2:0] PadPlan  [0:RandomPhases-1] = '{0, 3, 0, 7, 5, 7, 1, 0, 0};

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_push  = 1'b0;
   logic                     req_full;
   req_type                  req_data  = '0;
   logic                     rsp_empty;
   logic                     rsp_pop   = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   // Characters waiting to be sent and octets the packer still owes us.
   req_type     pending_chars [$];
   rsp_type     octets_due [$];
   logic        item_on_bus = 1'b0;
   int unsigned mismatches  = 0;
   int unsigned cycle_count = 0;

   // Shadow of the configuration and of the septet packing state.
   logic       ucs2_mode     = 1'b0;
   logic [2:0] pad_bits      = 3'd0;
   logic [6:0] held_bits     = 7'd0;
   logic [2:0] held_count    = 3'd0;
   logic       fresh_message = 1'b1;

   sms_text_gsm7_ucs2_packer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RunLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   function automatic logic [15:0] gsm_code_of(input logic [20:0] cp);
      for (int i = 0; i < 53; i++)
         if (cp == {5'd0, GsmPairs[i][31:16]}) return GsmPairs[i][15:0];
      if (cp == Backtick) return NoCode;
      if (cp >= AsciiLow && cp <= AsciiTop) return cp[15:0];
      return NoCode;
   endfunction

   function automatic void owe_octet(input logic [7:0] value, input status_type code);
      rsp_type r;
      r.out_byte   = value;
      r.status     = code;
      r.end_of_run = 1'b0;
      octets_due.push_back(r);
   endfunction

   function automatic void pack_septet(input logic [6:0] septet);
      logic [14:0] acc;
      int unsigned nbits;
      if (fresh_message) begin
         held_bits     = 7'd0;
         held_count    = pad_bits;
         fresh_message = 1'b0;
      end
      acc   = {8'd0, held_bits} | ({8'd0, septet} << held_count);
      nbits = held_count + 7;
      while (nbits >= 8) begin
         owe_octet(acc[7:0], StatusData);
         acc   = acc >> 8;
         nbits = nbits - 8;
      end
      held_bits  = acc[6:0];
      held_count = nbits[2:0];
   endfunction

   // Works out every octet or status that one accepted character causes.
   function automatic void predict_octets(input req_type ch);
      int unsigned first;
      logic [20:0] offs;
      logic [15:0] hi_unit;
      logic [15:0] lo_unit;
      logic [15:0] code;
      rsp_type     tail;
      first = octets_due.size();
      if (ucs2_mode) begin
         if (ch.code_point > MaxCp) begin
            owe_octet(8'h00, StatusNoMap);
         end else if (ch.code_point > BmpMax) begin
            offs    = ch.code_point - SuppBase;
            hi_unit = HiSurrBase + {6'd0, offs[19:10]};
            lo_unit = LoSurrBase + {6'd0, offs[9:0]};
            owe_octet(hi_unit[15:8], StatusData);
            owe_octet(hi_unit[7:0], StatusData);
            owe_octet(lo_unit[15:8], StatusData);
            owe_octet(lo_unit[7:0], StatusData);
         end else begin
            owe_octet(ch.code_point[15:8], StatusData);
            owe_octet(ch.code_point[7:0], StatusData);
         end
      end else begin
         code = gsm_code_of(ch.code_point);
         if (code == NoCode) begin
            owe_octet(8'h00, StatusNoMap);
         end else if (code[15:8] != 8'd0) begin
            pack_septet(EscSeptet);
            pack_septet(code[6:0]);
         end else begin
            pack_septet(code[6:0]);
         end
         if (ch.is_final && !fresh_message && held_count != 3'd0)
            owe_octet({1'b0, held_bits}, StatusData);
      end
      if (ch.is_final) begin
         held_bits     = 7'd0;
         held_count    = 3'd0;
         fresh_message = 1'b1;
         if (octets_due.size() == first) owe_octet(8'h00, StatusEnd);
         tail = octets_due.pop_back();
         tail.end_of_run = 1'b1;
         octets_due.push_back(tail);
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   always @(posedge clock) begin
      logic next_push;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         next_push = req_push;
         if (req_push && !req_full) begin
            predict_octets(req_data);
            item_on_bus = 1'b0;
            next_push   = 1'b0;
         end
         if (!item_on_bus) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_chars.size() > 0) begin
               req_data    <= pending_chars.pop_front();
               item_on_bus = 1'b1;
               next_push   = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_push <= next_push;
      end
   end

   // Receiver: pops on a rotating mask that is redrawn whenever mask_age wraps.
   logic [7:0] pop_mask    = 8'hFF;
   int unsigned mask_age   = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (octets_due.size() == 0) begin
               report_mismatch("unexpected item, out_byte", rsp_data.out_byte, 0);
            end else begin
               want = octets_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.end_of_run !== want.end_of_run)
                  report_mismatch("end_of_run", rsp_data.end_of_run, want.end_of_run);
            end
         end
         mask_age++;
         if (mask_age == 64) begin
            mask_age = 0;
            case ($urandom_range(0, 3))
               0: pop_mask = 8'hFF;
               1: pop_mask = 8'($urandom_range(0, 255));
               2: pop_mask = 8'h11;
               default: pop_mask = 8'h80;
            endcase
         end else begin
            pop_mask = {pop_mask[0], pop_mask[7:1]};
         end
         rsp_pop <= pop_mask[0];
      end
   end

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrEncodingMode) ucs2_mode = value[0];
      else if (idx == CsrLeadPadBits) pad_bits = value;
   endtask

   task automatic set_config(input logic mode, input logic [2:0] pad);
      write_csr(CsrEncodingMode, {2'b00, mode});
      write_csr(CsrLeadPadBits, pad);
   endtask

   function automatic void add_char(input logic [20:0] cp, input logic fin);
      req_type ch;
      ch.code_point = cp;
      ch.is_final   = fin;
      pending_chars.push_back(ch);
   endfunction

   function automatic logic [20:0] random_char();
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5: return 21'($urandom_range(AsciiLow, AsciiTop));
         6, 7:   return {5'd0, GsmPairs[$urandom_range(0, 52)][31:16]};
         8:      return {5'd0, GsmPairs[$urandom_range(FirstEscPair, 52)][31:16]};
         9:      return Backtick;
         10:     return 21'($urandom_range(0, 16'hFFFF));
         11:     return 21'($urandom_range(21'h10000, 21'h10FFFF));
         12:     return 21'($urandom_range(21'h110000, 21'h1FFFFF));
         13:     return 21'($urandom_range(0, 21'h1F));
         default: return 21'($urandom_range(21'h80, 21'h3FF));
      endcase
   endfunction

   // Mostly whole messages; a few runs carry random final flags, and a phase
   // may end with a message still open so the next settings apply mid-message.
   function automatic void queue_messages(input int unsigned target);
      int unsigned made;
      int unsigned len;
      logic        noisy;
      made = 0;
      while (made < target) begin
         len   = $urandom_range(1, 10);
         noisy = ($urandom_range(0, 7) == 0);
         for (int k = 0; k < len; k++)
            add_char(random_char(), noisy ? 1'($urandom_range(0, 1)) : (k == len - 1));
         made += len;
      end
      if ($urandom_range(0, 2) == 0) add_char(random_char(), 1'b0);
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_chars.size() != 0 || item_on_bus || octets_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // GSM without padding: plain, table, escape and unmappable characters.
      set_config(1'b0, 3'd0);
      add_char(21'h40, 1'b0);
      add_char(21'h7E, 1'b0);
      add_char(21'h20AC, 1'b0);
      add_char(Backtick, 1'b0);
      add_char(21'h20, 1'b0);
      add_char(21'h7D, 1'b0);
      add_char(21'h0A, 1'b0);
      add_char(21'h0D, 1'b0);
      add_char(21'h394, 1'b0);
      add_char(21'hE0, 1'b0);
      add_char(21'h1FFFFF, 1'b0);
      add_char(21'h0, 1'b0);
      add_char(21'h41, 1'b1);
      // Unmappable final at the start of a message must not flush a pad octet.
      add_char(Backtick, 1'b1);
      // Leaves bits pending that the UCS-2 final below has to drop.
      add_char(21'h48, 1'b0);
      wait_drained();

      // UCS-2 extremes, a lone surrogate and both ends of the plane range.
      set_config(1'b1, 3'd7);
      add_char(21'h0, 1'b0);
      add_char(21'hFFFF, 1'b0);
      add_char(21'hD800, 1'b0);
      add_char(21'h10000, 1'b0);
      add_char(21'h10FFFF, 1'b0);
      add_char(21'h110000, 1'b0);
      add_char(21'h20AC, 1'b1);
      wait_drained();

      set_config(1'b0, 3'd7);
      add_char(21'h41, 1'b1);
      add_char(21'h5E, 1'b1);
      wait_drained();

      // One pad bit plus one septet fills an octet exactly: nothing to flush.
      set_config(1'b0, 3'd1);
      add_char(21'h41, 1'b1);
      wait_drained();

      for (int p = 0; p < RandomPhases; p++) begin
         if (p >= RandomPhases - 2)
            set_config(ModePlan[p], 3'($urandom_range(0, 7)));
         else
            set_config(ModePlan[p], PadPlan[p]);
         queue_messages(PhaseChars);
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
